>>> src/fcsc_pkg.sv
// Shared types, register map, constants and the cosine weight table of the fan curve controller.
package fcsc_pkg;

   localparam int MaxPointsDefault = 8;
   localparam int CsrAddrWidth     = 6;
   localparam int CsrDataWidth     = 64;

   localparam logic [2:0] REG_POINT_COUNT  = 3'd0;
   localparam logic [2:0] REG_CURVE_TEMPS  = 3'd1;
   localparam logic [2:0] REG_CURVE_SPEEDS = 3'd2;
   localparam logic [2:0] REG_AGGRESSIVE   = 3'd3;
   localparam logic [2:0] REG_COSINE       = 3'd4;
   localparam logic [2:0] REG_PWM_LOW      = 3'd5;
   localparam logic [2:0] REG_PWM_HIGH     = 3'd6;

   localparam logic [6:0] SpeedMax = 7'd100;

   localparam logic [18:0] Div1000Mult  = 19'd268436;
   localparam int          Div1000Shift = 28;
   localparam logic [12:0] LinDivMult   = 13'd5243;
   localparam int          LinDivShift  = 19;
   localparam logic [14:0] PwmDivMult   = 15'd20972;
   localparam int          PwmDivShift  = 21;

   localparam logic [63:0] PiQ30 = 64'd3373259426;
   localparam int          CosTableDepth = 128;
   localparam int          CosTableLast  = 100;
   localparam logic [63:0] TaylorDiv [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

   typedef enum logic [1:0] {
      ACT_TICK           = 2'd0,
      ACT_SET_OVERRIDE   = 2'd1,
      ACT_CLEAR_OVERRIDE = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TMUL,
      ST_SEARCH,
      ST_PREP,
      ST_DIV,
      ST_BMUL,
      ST_BDIV,
      ST_UPDATE,
      ST_PMUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [3:0]  point_count;
      logic [63:0] curve_temps;
      logic [63:0] curve_speeds;
      logic        aggressive_mode;
      logic        cosine_mode;
      logic [7:0]  pwm_low;
      logic [7:0]  pwm_high;
   } cfg_type;

   typedef struct packed {
      logic latch_in;
      logic tmul;
      logic search;
      logic prep;
      logic div_step;
      logic bmul;
      logic bdiv;
      logic update;
      logic pmul;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic curve_needed;
      logic direct;
      logic div_last;
   } status_type;

   typedef logic [16:0] cos_table_type [0:CosTableDepth-1];

   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      logic [63:0]   x;
      logic [63:0]   term;
      logic [63:0]   sum;
      logic [63:0]   sq;
      for (int p = 0; p < CosTableDepth; p++) begin
         tbl[p] = '0;
      end
      for (int p = 0; p <= CosTableLast; p++) begin
         x    = (PiQ30 * 64'(p)) / 64'd200;
         term = x;
         sum  = x;
         for (int k = 1; k <= 7; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / TaylorDiv[k];
            if ((k % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sq     = sum * sum + (64'd1 << 43);
         tbl[p] = 17'(sq >> 44);
      end
      return tbl;
   endfunction

   localparam cos_table_type CosTable = build_cos_table();

   function automatic logic [7:0] byte_at(input logic [63:0] packed_val, input logic [2:0] idx);
      return packed_val[8*idx +: 8];
   endfunction

   function automatic logic [6:0] speed_at(input logic [63:0] packed_val, input logic [2:0] idx);
      logic [7:0] s;
      s = packed_val[8*idx +: 8];
      return (s > 8'(SpeedMax)) ? SpeedMax : s[6:0];
   endfunction

endpackage

>>> src/fcsc_csr.sv
// Configuration register file with an APB-style write and read port.
module fcsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fcsc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [fcsc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [fcsc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output fcsc_pkg::cfg_type                    cfg
);
   import fcsc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[5:3];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_POINT_COUNT:  cfg_in.point_count     = csr_pwdata[3:0];
            REG_CURVE_TEMPS:  cfg_in.curve_temps     = csr_pwdata;
            REG_CURVE_SPEEDS: cfg_in.curve_speeds    = csr_pwdata;
            REG_AGGRESSIVE:   cfg_in.aggressive_mode = csr_pwdata[0];
            REG_COSINE:       cfg_in.cosine_mode     = csr_pwdata[0];
            REG_PWM_LOW:      cfg_in.pwm_low         = csr_pwdata[7:0];
            REG_PWM_HIGH:     cfg_in.pwm_high        = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_POINT_COUNT:  csr_prdata = 64'(cfg_ff.point_count);
         REG_CURVE_TEMPS:  csr_prdata = cfg_ff.curve_temps;
         REG_CURVE_SPEEDS: csr_prdata = cfg_ff.curve_speeds;
         REG_AGGRESSIVE:   csr_prdata = 64'(cfg_ff.aggressive_mode);
         REG_COSINE:       csr_prdata = 64'(cfg_ff.cosine_mode);
         REG_PWM_LOW:      csr_prdata = 64'(cfg_ff.pwm_low);
         REG_PWM_HIGH:     csr_prdata = 64'(cfg_ff.pwm_high);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point_count     <= 4'd1;
         cfg_ff.curve_temps     <= '0;
         cfg_ff.curve_speeds    <= '0;
         cfg_ff.aggressive_mode <= 1'b0;
         cfg_ff.cosine_mode     <= 1'b0;
         cfg_ff.pwm_low         <= 8'd0;
         cfg_ff.pwm_high        <= 8'hFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/fcsc_ctrl.sv
// Control state machine that sequences the datapath and owns both handshakes.
module fcsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  fcsc_pkg::status_type status,
   output fcsc_pkg::cmd_type    cmd
);
   import fcsc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = status.curve_needed ? ST_TMUL : ST_UPDATE;
         ST_TMUL:     state_in = ST_SEARCH;
         ST_SEARCH:   state_in = status.direct ? ST_UPDATE : ST_PREP;
         ST_PREP:     state_in = ST_DIV;
         ST_DIV:      if (status.div_last) state_in = ST_BMUL;
         ST_BMUL:     state_in = ST_BDIV;
         ST_BDIV:     state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_PMUL;
         ST_PMUL:     state_in = ST_OUT;
         ST_OUT:      if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.latch_in = req_valid;
         ST_TMUL:   cmd.tmul     = 1'b1;
         ST_SEARCH: cmd.search   = 1'b1;
         ST_PREP:   cmd.prep     = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_BMUL:   cmd.bmul     = 1'b1;
         ST_BDIV:   cmd.bdiv     = 1'b1;
         ST_UPDATE: cmd.update   = 1'b1;
         ST_PMUL:   cmd.pmul     = 1'b1;
         ST_OUT:    cmd.load_out = slot_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/fcsc_dp.sv
// Datapath: curve search, iterative percentage divider, interpolation, speed state and pwm scaling.
module fcsc_dp #(
   parameter int MaxPoints = fcsc_pkg::MaxPointsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fcsc_pkg::cfg_type    cfg,
   input  fcsc_pkg::cmd_type    cmd,
   output fcsc_pkg::status_type status,
   input  logic [1:0]           req_action,
   input  logic [17:0]          req_temp_millideg,
   input  logic [6:0]           req_override_pct,
   input  logic                 req_override_detached,
   input  logic                 req_owner_alive,
   output logic                 rsp_pwm_write,
   output logic [7:0]           rsp_pwm_value,
   output logic [6:0]           rsp_speed_now,
   output logic                 rsp_override_on
);
   import fcsc_pkg::*;

   logic [1:0]  action_ff;
   logic [17:0] temp_ff;
   logic [6:0]  ovr_pct_ff;
   logic        detached_ff;
   logic        alive_ff;

   logic [7:0]  t_ff,      t_in;
   logic [6:0]  res_ff,    res_in;
   logic [7:0]  lo_ff,     lo_in;
   logic [7:0]  hi_ff,     hi_in;
   logic [6:0]  a_ff,      a_in;
   logic [6:0]  b_ff,      b_in;
   logic [14:0] rem_ff,    rem_in;
   logic [14:0] dsh_ff,    dsh_in;
   logic [6:0]  quo_ff,    quo_in;
   logic [2:0]  cnt_ff,    cnt_in;
   logic [23:0] prod_ff,   prod_in;
   logic        neg_ff,    neg_in;
   logic [14:0] pprod_ff,  pprod_in;

   logic [6:0]  last_ff,   last_in;
   logic        lvalid_ff, lvalid_in;
   logic        ovr_ff,    ovr_in;
   logic        noown_ff,  noown_in;
   logic        wrote_ff,  wrote_in;

   logic        out_write_ff;
   logic [7:0]  out_pwm_ff;
   logic [6:0]  out_speed_ff;
   logic        out_ovr_ff;

   logic [36:0] t_prod;
   logic [8:0]  t_full;
   logic [3:0]  n_eff;
   logic [2:0]  last_idx;
   logic [2:0]  idx;
   logic        found;
   logic        below0;
   logic        use_first;
   logic        direct;
   logic [6:0]  mag;
   logic [16:0] weight;
   logic [26:0] lin_prod;
   logic [6:0]  q;
   logic [6:0]  ovr_sat;
   logic [6:0]  speed_cur;
   logic [7:0]  span;
   logic [29:0] pwm_full;

   // Tick temperature in degrees by reciprocal multiplication, saturated at 255.
   assign t_prod = 37'(temp_ff) * 37'(Div1000Mult);
   assign t_full = t_prod[Div1000Shift +: 9];

   always_comb begin
      if (cfg.point_count == 4'd0) begin
         n_eff = 4'd1;
      end else if (cfg.point_count > 4'(MaxPoints)) begin
         n_eff = 4'(MaxPoints);
      end else begin
         n_eff = cfg.point_count;
      end
      last_idx = 3'(n_eff - 4'd1);
      idx      = last_idx;
      found    = 1'b0;
      for (int i = 0; i < MaxPoints - 1; i++) begin
         if (!found && (4'(i + 1) < n_eff) &&
             (t_ff < byte_at(cfg.curve_temps, 3'(i + 1)))) begin
            idx   = 3'(i);
            found = 1'b1;
         end
      end
      below0    = t_ff < byte_at(cfg.curve_temps, 3'd0);
      use_first = below0 || (cfg.aggressive_mode && (idx == 3'd0));
      direct    = use_first || (idx == last_idx);
   end

   assign status.curve_needed = (action_ff == ACT_TICK) && !ovr_ff;
   assign status.direct       = direct;
   assign status.div_last     = (cnt_ff == 3'd0);

   assign mag      = neg_ff ? (a_ff - b_ff) : (b_ff - a_ff);
   assign weight   = cfg.cosine_mode ? CosTable[quo_ff] : 17'(quo_ff);
   assign lin_prod = 27'(prod_ff[13:0]) * 27'(LinDivMult);
   assign q        = cfg.cosine_mode ? 7'(prod_ff >> 16) : 7'(lin_prod >> LinDivShift);
   assign ovr_sat  = (ovr_pct_ff > SpeedMax) ? SpeedMax : ovr_pct_ff;

   assign speed_cur = lvalid_ff ? last_ff : 7'd0;
   assign span      = (cfg.pwm_high >= cfg.pwm_low) ? (cfg.pwm_high - cfg.pwm_low) : 8'd0;
   assign pwm_full  = 30'(pprod_ff) * 30'(PwmDivMult);

   always_comb begin
      t_in     = t_ff;
      res_in   = res_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      pprod_in = pprod_ff;
      if (cmd.tmul) begin
         t_in = (t_full > 9'd255) ? 8'd255 : t_full[7:0];
      end
      if (cmd.search) begin
         res_in = use_first ? speed_at(cfg.curve_speeds, 3'd0)
                            : speed_at(cfg.curve_speeds, last_idx);
         lo_in  = byte_at(cfg.curve_temps, idx);
         hi_in  = byte_at(cfg.curve_temps, idx + 3'd1);
         a_in   = speed_at(cfg.curve_speeds, idx);
         b_in   = speed_at(cfg.curve_speeds, idx + 3'd1);
      end
      if (cmd.prep) begin
         rem_in = 15'(t_ff - lo_ff) * 15'd100;
         dsh_in = 15'(hi_ff - lo_ff) << 6;
         quo_in = 7'd0;
         cnt_in = 3'd6;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[5:0], 1'b1};
         end else begin
            quo_in = {quo_ff[5:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 3'd1;
      end
      if (cmd.bmul) begin
         prod_in = 24'(mag) * 24'(weight);
      end
      if (cmd.bdiv) begin
         res_in = neg_ff ? (a_ff - q) : (a_ff + q);
      end
      if (cmd.search) begin
         neg_in = speed_at(cfg.curve_speeds, idx + 3'd1) < speed_at(cfg.curve_speeds, idx);
      end
      if (cmd.pmul) begin
         pprod_in = 15'(speed_cur) * 15'(span);
      end
   end

   always_comb begin
      last_in   = last_ff;
      lvalid_in = lvalid_ff;
      ovr_in    = ovr_ff;
      noown_in  = noown_ff;
      wrote_in  = wrote_ff;
      if (cmd.update) begin
         wrote_in = 1'b0;
         case (action_ff)
            ACT_TICK: begin
               if (ovr_ff) begin
                  if (!noown_ff && !alive_ff) begin
                     ovr_in   = 1'b0;
                     noown_in = 1'b0;
                  end
               end else begin
                  wrote_in  = !(lvalid_ff && (last_ff == res_ff));
                  last_in   = res_ff;
                  lvalid_in = 1'b1;
               end
            end
            ACT_SET_OVERRIDE: begin
               ovr_in    = 1'b1;
               noown_in  = detached_ff;
               wrote_in  = !(lvalid_ff && (last_ff == ovr_sat));
               last_in   = ovr_sat;
               lvalid_in = 1'b1;
            end
            ACT_CLEAR_OVERRIDE: begin
               ovr_in   = 1'b0;
               noown_in = 1'b0;
            end
            default: wrote_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         action_ff   <= req_action;
         temp_ff     <= req_temp_millideg;
         ovr_pct_ff  <= req_override_pct;
         detached_ff <= req_override_detached;
         alive_ff    <= req_owner_alive;
      end
      t_ff     <= t_in;
      res_ff   <= res_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      pprod_ff <= pprod_in;
      wrote_ff <= wrote_in;
      if (cmd.load_out) begin
         out_write_ff <= wrote_ff;
         out_pwm_ff   <= 8'(pwm_full >> PwmDivShift);
         out_speed_ff <= speed_cur;
         out_ovr_ff   <= ovr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= 7'd0;
         lvalid_ff <= 1'b0;
         ovr_ff    <= 1'b0;
         noown_ff  <= 1'b0;
      end else begin
         last_ff   <= last_in;
         lvalid_ff <= lvalid_in;
         ovr_ff    <= ovr_in;
         noown_ff  <= noown_in;
      end
   end

   assign rsp_pwm_write   = out_write_ff;
   assign rsp_pwm_value   = out_pwm_ff;
   assign rsp_speed_now   = out_speed_ff;
   assign rsp_override_on = out_ovr_ff;

endmodule

>>> src/fan_curve_speed_controller_unit.sv
// Top level of the fan curve speed controller: register file, controller and datapath.
//
// Items enter on the req_ channel (valid/ready) and each one yields exactly one
// item on the rsp_ channel. A tick item turns a temperature into a fan speed
// through the configured curve, a set item pins an override speed and a clear
// item releases it. The user must program the curve through the csr_ port only
// while the block is idle; the block itself does not enforce this. Writes complete
// in the APB access cycle with no wait. An interpolating tick runs through
// dispatch, a reciprocal multiply, the segment search, divider setup, seven steps
// of the restoring divider, the blend multiply and divide, the speed update, the
// pwm multiply and output load. A tick that lands below the first point, on an
// aggressive first segment or at or past the last point skips the divider and the
// blend; a tick under an override and every other item go from dispatch to the
// speed update. One item is in flight at a time: req_ready rises at the edge that
// loads the output register. The output register lets the next item be accepted
// while a result waits; if the receiver still stalls when that next result is done,
// the controller holds it until the output register frees up.
// Reset clears the speed and override state and loads the register defaults.
module fan_curve_speed_controller_unit #(
   parameter int MaxPoints = fcsc_pkg::MaxPointsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [17:0]                       req_temp_millideg,
   input  logic [6:0]                        req_override_pct,
   input  logic                              req_override_detached,
   input  logic                              req_owner_alive,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pwm_write,
   output logic [7:0]                        rsp_pwm_value,
   output logic [6:0]                        rsp_speed_now,
   output logic                              rsp_override_on,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fcsc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [fcsc_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [fcsc_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                              csr_pready
);
   import fcsc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   fcsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fcsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcsc_dp #(
      .MaxPoints (MaxPoints)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .status                (status),
      .req_action            (req_action),
      .req_temp_millideg     (req_temp_millideg),
      .req_override_pct      (req_override_pct),
      .req_override_detached (req_override_detached),
      .req_owner_alive       (req_owner_alive),
      .rsp_pwm_write         (rsp_pwm_write),
      .rsp_pwm_value         (rsp_pwm_value),
      .rsp_speed_now         (rsp_speed_now),
      .rsp_override_on       (rsp_override_on)
   );

endmodule

>>> dv/fcsc_result_checker.sv
// Checker that predicts every fan controller result from the accepted items and compares it.
module fcsc_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [17:0]                       req_temp_millideg,
   input  logic [6:0]                        req_override_pct,
   input  logic                              req_override_detached,
   input  logic                              req_owner_alive,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_pwm_write,
   input  logic [7:0]                        rsp_pwm_value,
   input  logic [6:0]                        rsp_speed_now,
   input  logic                              rsp_override_on,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [fcsc_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [fcsc_pkg::CsrDataWidth-1:0] csr_pwdata,
   output int unsigned                       failures,
   output int unsigned                       outstanding
);
   import fcsc_pkg::*;

   typedef struct packed {
      logic       pwm_write;
      logic [7:0] pwm_value;
      logic [6:0] speed_now;
      logic       override_on;
   } fan_result_type;

   logic [3:0]  cfg_points;
   logic [63:0] cfg_temps;
   logic [63:0] cfg_speeds;
   logic        cfg_aggressive;
   logic        cfg_cosine;
   logic [7:0]  cfg_pwm_lo;
   logic [7:0]  cfg_pwm_hi;

   logic [6:0]  held_speed;
   logic        speed_known;
   logic        override_held;
   logic        override_free;

   fan_result_type speed_q[$];
   int unsigned    errors = 0;

   assign failures = errors;

   // Weight of a cosine blend: the rounded square of sin(pi*step/200) in Q16.
   function automatic logic [16:0] cosine_weight(input int unsigned step);
      logic [63:0] angle;
      logic [63:0] term;
      logic [63:0] acc;
      angle = (PiQ30 * 64'(step)) / 64'd200;
      term  = angle;
      acc   = angle;
      for (int k = 1; k <= 7; k++) begin
         term = (((term * angle) >> 30) * angle) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return 17'((acc * acc + (64'd1 << 43)) >> 44);
   endfunction

   function automatic logic [7:0] curve_byte(input logic [63:0] bytes, input int idx);
      return bytes[8*idx +: 8];
   endfunction

   function automatic logic [6:0] point_speed(input int idx);
      logic [7:0] s;
      s = curve_byte(cfg_speeds, idx);
      return (s > 8'd100) ? 7'd100 : s[6:0];
   endfunction

   function automatic logic [6:0] interpolate(input logic [6:0] a, input logic [6:0] b,
                                              input longint num, input longint den);
      longint diff;
      longint prod;
      longint quot;
      diff = longint'(b) - longint'(a);
      prod = diff * num;
      if (prod >= 0) begin
         quot = prod / den;
      end else begin
         quot = -((-prod) / den);
      end
      return 7'(longint'(a) + quot);
   endfunction

   function automatic logic [6:0] curve_speed(input logic [17:0] mdeg);
      int unsigned deg;
      int unsigned n;
      int unsigned seg;
      int unsigned lo;
      int unsigned hi;
      int unsigned pct;
      bit          found;
      deg = 32'(mdeg) / 32'd1000;
      if (deg > 255) begin
         deg = 255;
      end
      n = cfg_points;
      if (n == 0) begin
         n = 1;
      end
      if (n > MaxPointsDefault) begin
         n = MaxPointsDefault;
      end
      if (deg < curve_byte(cfg_temps, 0)) begin
         return point_speed(0);
      end
      seg   = n - 1;
      found = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
         if (!found && deg < curve_byte(cfg_temps, i + 1)) begin
            seg   = i;
            found = 1'b1;
         end
      end
      if (cfg_aggressive && seg == 0) begin
         return point_speed(0);
      end
      if (seg >= n - 1) begin
         return point_speed(n - 1);
      end
      lo  = curve_byte(cfg_temps, seg);
      hi  = curve_byte(cfg_temps, seg + 1);
      pct = ((deg - lo) * 100) / (hi - lo);
      if (cfg_cosine) begin
         return interpolate(point_speed(seg), point_speed(seg + 1), cosine_weight(pct), 65536);
      end
      return interpolate(point_speed(seg), point_speed(seg + 1), pct, 100);
   endfunction

   function automatic logic commit_speed(input logic [6:0] target);
      if (speed_known && held_speed == target) begin
         return 1'b0;
      end
      held_speed  = target;
      speed_known = 1'b1;
      return 1'b1;
   endfunction

   function automatic fan_result_type predict_fan_result(input logic [1:0] action,
                                                         input logic [17:0] mdeg,
                                                         input logic [6:0] opct,
                                                         input logic detached,
                                                         input logic alive);
      fan_result_type r;
      logic [6:0]     shown;
      logic [7:0]     span;
      r = '0;
      case (action_type'(action))
         ACT_TICK: begin
            if (override_held) begin
               if (!override_free && !alive) begin
                  override_held = 1'b0;
                  override_free = 1'b0;
               end
            end else begin
               r.pwm_write = commit_speed(curve_speed(mdeg));
            end
         end
         ACT_SET_OVERRIDE: begin
            override_held = 1'b1;
            override_free = detached;
            r.pwm_write   = commit_speed((opct > SpeedMax) ? SpeedMax : opct);
         end
         ACT_CLEAR_OVERRIDE: begin
            override_held = 1'b0;
            override_free = 1'b0;
         end
         default: begin
         end
      endcase
      shown         = speed_known ? held_speed : 7'd0;
      span          = (cfg_pwm_hi >= cfg_pwm_lo) ? cfg_pwm_hi - cfg_pwm_lo : 8'd0;
      r.pwm_value   = 8'((int'(shown) * int'(span)) / 100);
      r.speed_now   = shown;
      r.override_on = override_held;
      return r;
   endfunction

   task automatic report(input string what, input longint want, input longint got);
      errors++;
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      fan_result_type want;
      if (reset) begin
         cfg_points     = 4'd1;
         cfg_temps      = '0;
         cfg_speeds     = '0;
         cfg_aggressive = 1'b0;
         cfg_cosine     = 1'b0;
         cfg_pwm_lo     = 8'd0;
         cfg_pwm_hi     = 8'd255;
         held_speed     = '0;
         speed_known    = 1'b0;
         override_held  = 1'b0;
         override_free  = 1'b0;
         speed_q.delete();
         outstanding   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (speed_q.size() == 0) begin
               report("result with no item pending, speed_now", -1, rsp_speed_now);
            end else begin
               want = speed_q.pop_front();
               if (rsp_pwm_write !== want.pwm_write) begin
                  report("pwm_write", want.pwm_write, rsp_pwm_write);
               end
               if (rsp_pwm_value !== want.pwm_value) begin
                  report("pwm_value", want.pwm_value, rsp_pwm_value);
               end
               if (rsp_speed_now !== want.speed_now) begin
                  report("speed_now", want.speed_now, rsp_speed_now);
               end
               if (rsp_override_on !== want.override_on) begin
                  report("override_on", want.override_on, rsp_override_on);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CsrAddrWidth-1:3])
               REG_POINT_COUNT:  cfg_points     = csr_pwdata[3:0];
               REG_CURVE_TEMPS:  cfg_temps      = csr_pwdata[63:0];
               REG_CURVE_SPEEDS: cfg_speeds     = csr_pwdata[63:0];
               REG_AGGRESSIVE:   cfg_aggressive = csr_pwdata[0];
               REG_COSINE:       cfg_cosine     = csr_pwdata[0];
               REG_PWM_LOW:      cfg_pwm_lo     = csr_pwdata[7:0];
               REG_PWM_HIGH:     cfg_pwm_hi     = csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            speed_q.push_back(predict_fan_result(req_action, req_temp_millideg, req_override_pct,
                                                 req_override_detached, req_owner_alive));
         end
         outstanding <= speed_q.size();
      end
   end

endmodule

>>> dv/tb_fan_curve_speed_controller_unit.sv
// Testbench top of the fan curve speed controller: clock, reset, stimulus and verdict.
module tb_fan_curve_speed_controller_unit;
   import fcsc_pkg::*;

   localparam logic [1:0] ActIgnored  = 2'd3;
   localparam int         IdlePercent = 15;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_action;
   logic [17:0]             req_temp_millideg;
   logic [6:0]              req_override_pct;
   logic                    req_override_detached;
   logic                    req_owner_alive;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_pwm_write;
   logic [7:0]              rsp_pwm_value;
   logic [6:0]              rsp_speed_now;
   logic                    rsp_override_on;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned failures;
   int unsigned outstanding;
   logic        quiet;
   logic [63:0] cur_temps;

   fan_curve_speed_controller_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_temp_millideg     (req_temp_millideg),
      .req_override_pct      (req_override_pct),
      .req_override_detached (req_override_detached),
      .req_owner_alive       (req_owner_alive),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pwm_write         (rsp_pwm_write),
      .rsp_pwm_value         (rsp_pwm_value),
      .rsp_speed_now         (rsp_speed_now),
      .rsp_override_on       (rsp_override_on),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   fcsc_result_checker speed_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_temp_millideg     (req_temp_millideg),
      .req_override_pct      (req_override_pct),
      .req_override_detached (req_override_detached),
      .req_owner_alive       (req_owner_alive),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pwm_write         (rsp_pwm_write),
      .rsp_pwm_value         (rsp_pwm_value),
      .rsp_speed_now         (rsp_speed_now),
      .rsp_override_on       (rsp_override_on),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_pready            (csr_pready),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .failures              (failures),
      .outstanding           (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= IdlePercent);
   end

   task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic load_curve(input logic [3:0] points, input logic [63:0] temps,
                             input logic [63:0] speeds, input logic aggressive,
                             input logic cosine, input logic [7:0] pwm_lo,
                             input logic [7:0] pwm_hi);
      write_reg(REG_POINT_COUNT, 64'(points));
      write_reg(REG_CURVE_TEMPS, temps);
      write_reg(REG_CURVE_SPEEDS, speeds);
      write_reg(REG_AGGRESSIVE, 64'(aggressive));
      write_reg(REG_COSINE, 64'(cosine));
      write_reg(REG_PWM_LOW, 64'(pwm_lo));
      write_reg(REG_PWM_HIGH, 64'(pwm_hi));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cur_temps    = temps;
   endtask

   task automatic send_item(input logic [1:0] action, input logic [17:0] mdeg,
                            input logic [6:0] opct, input logic detached, input logic alive);
      if (!quiet && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_action            <= action;
      req_temp_millideg     <= mdeg;
      req_override_pct      <= opct;
      req_override_detached <= detached;
      req_owner_alive       <= alive;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [63:0] rising_temps();
      logic [63:0]  t;
      int unsigned  at;
      at = $urandom_range(0, 40);
      for (int i = 0; i < 8; i++) begin
         t[8*i +: 8] = 8'(at);
         at = at + $urandom_range(1, 40);
         if (at > 255) begin
            at = 255;
         end
      end
      return t;
   endfunction

   function automatic logic [63:0] random_speeds();
      logic [63:0] s;
      for (int i = 0; i < 8; i++) begin
         s[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(101, 255))
                                                   : 8'($urandom_range(0, 100));
      end
      return s;
   endfunction

   task automatic random_item();
      int unsigned  pick;
      int unsigned  sel;
      logic [1:0]   action;
      logic [17:0]  mdeg;
      logic [6:0]   opct;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      if (pick < 72) begin
         action = ACT_TICK;
      end else if (pick < 84) begin
         action = ACT_SET_OVERRIDE;
      end else if (pick < 96) begin
         action = ACT_CLEAR_OVERRIDE;
      end else begin
         action = ActIgnored;
      end
      if (sel == 0) begin
         mdeg = 18'($urandom_range(256000, 262143));
      end else if (sel < 4) begin
         mdeg = 18'(cur_temps[8*$urandom_range(0, 7) +: 8] * 1000 + $urandom_range(0, 999));
      end else begin
         mdeg = 18'($urandom_range(0, 255999));
      end
      opct = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                         : 7'($urandom_range(0, 100));
      send_item(action, mdeg, opct, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 80);
   endtask

   initial begin
      reset                 <= 1'b1;
      quiet                 <= 1'b0;
      req_valid             <= 1'b0;
      req_action            <= ACT_TICK;
      req_temp_millideg     <= '0;
      req_override_pct      <= '0;
      req_override_detached <= 1'b0;
      req_owner_alive       <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      cur_temps              = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default curve: nothing set yet, then a single point and a hot sensor.
      send_item(ActIgnored, 18'd0, 7'd0, 1'b0, 1'b0);
      send_item(ACT_CLEAR_OVERRIDE, 18'd0, 7'd0, 1'b0, 1'b0);
      send_item(ACT_TICK, 18'd0, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'h3FFFF, 7'd0, 1'b0, 1'b1);
      wait_drained();

      load_curve(4'd5, 64'h0000_005A_4632_1E0A, 64'h0000_00C8_503C_2314, 1'b0, 1'b0,
                 8'd10, 8'd250);
      send_item(ACT_TICK, 18'd5000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd10000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd29999, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd45500, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd90000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd255999, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd255999, 7'd0, 1'b0, 1'b1);
      send_item(ACT_SET_OVERRIDE, 18'd0, 7'd127, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd40000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd40000, 7'd0, 1'b0, 1'b0);
      send_item(ACT_SET_OVERRIDE, 18'd0, 7'd0, 1'b1, 1'b1);
      send_item(ACT_TICK, 18'd40000, 7'd0, 1'b0, 1'b0);
      send_item(ACT_CLEAR_OVERRIDE, 18'd0, 7'd0, 1'b0, 1'b1);
      send_item(ACT_SET_OVERRIDE, 18'd0, 7'd100, 1'b0, 1'b1);
      send_item(ActIgnored, 18'd0, 7'd0, 1'b0, 1'b1);
      send_item(ACT_CLEAR_OVERRIDE, 18'd0, 7'd0, 1'b0, 1'b1);
      wait_drained();

      // Unordered temperatures, too many points, cosine blend and inverted pwm limits.
      load_curve(4'd15, 64'hF020_C080_60A0_4005, 64'h6400_FF10_3250_0A5A, 1'b1, 1'b1,
                 8'd200, 8'd100);
      send_item(ACT_TICK, 18'd3000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd30000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd100000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd200000, 7'd0, 1'b0, 1'b1);
      send_item(ACT_TICK, 18'd255999, 7'd0, 1'b0, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: load_curve(4'd8, 64'hFFDA_B48E_6844_2200, 64'h6450_3C28_1E14_0A00, 1'b0, 1'b1,
                          8'd0, 8'd255);
            1: load_curve(4'd15, '1, '1, 1'b1, 1'b1, 8'd255, 8'd255);
            2: load_curve(4'd0, rising_temps(), random_speeds(), 1'b0, 1'b0,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            3: load_curve(4'd2, rising_temps(), random_speeds(), 1'b1, 1'b0, 8'd0, 8'd100);
            4: load_curve(4'($urandom_range(0, 15)), {$urandom, $urandom},
                          {$urandom, $urandom}, 1'($urandom), 1'($urandom),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: load_curve(4'($urandom_range(1, 8)), rising_temps(), random_speeds(),
                                1'($urandom), 1'($urandom), 8'($urandom_range(0, 60)),
                                8'($urandom_range(150, 255)));
         endcase
         quiet <= (ph == 6);
         for (int k = 0; k < 100; k++) begin
            random_item();
         end
         wait_drained();
      end

      quiet <= 1'b0;
      repeat (24) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
